FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/chc_pkg.sv
// Types, codes and constants of the climate hysteresis controller.
`timescale 1ns / 1ps

package chc_pkg;

  // Comparison width: wide enough for every field plus or minus any margin.
  localparam int CMP_W = 18;
  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_MAX      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_MIN       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HUM_MAX       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CO2_MAX       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_MODE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_TRIP     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_RELEASE  = 3'd7;

  // Request kinds.
  localparam logic [1:0] KIND_EVAL   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_LIGHT  = 2'd2;

  // Alarm codes.
  localparam logic [2:0] ALARM_NONE          = 3'd0;
  localparam logic [2:0] ALARM_OVERHEAT      = 3'd1;
  localparam logic [2:0] ALARM_HIGH_TEMP     = 3'd2;
  localparam logic [2:0] ALARM_LOW_TEMP      = 3'd3;
  localparam logic [2:0] ALARM_HIGH_HUM      = 3'd4;
  localparam logic [2:0] ALARM_LOW_HUM       = 3'd5;
  localparam logic [2:0] ALARM_HIGH_CO2      = 3'd6;
  localparam logic [2:0] ALARM_OVERHEAT_CLEAR = 3'd7;

  // Overheat status codes as reported on the result channel.
  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_ACTIVE   = 2'd1;
  localparam logic [1:0] STATUS_RECOVERY = 2'd2;

  // Hysteresis bands and fixed margins, all in sensor units.
  localparam cmp_t TEMP_BAND         = cmp_t'(5);
  localparam cmp_t HUM_BAND          = cmp_t'(30);
  localparam cmp_t CO2_BAND          = cmp_t'(100);
  localparam cmp_t VENT_MARGIN       = cmp_t'(10);
  localparam cmp_t ALARM_TEMP_MARGIN = cmp_t'(30);
  localparam cmp_t ALARM_HUM_MARGIN  = cmp_t'(50);
  localparam cmp_t ALARM_CO2_MARGIN  = cmp_t'(500);
  localparam cmp_t HUMID_BLOCK_TEMP  = cmp_t'(275);
  localparam cmp_t HUMID_STOP_TEMP   = cmp_t'(280);

  // Post-vent humidifier window in milliseconds.
  localparam logic [31:0] POST_DELAY_MS  = 32'd30000;
  localparam logic [31:0] POST_LENGTH_MS = 32'd60000;
  localparam logic [31:0] POST_END_MS    = POST_DELAY_MS + POST_LENGTH_MS;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'b001,
    MODE_OVERHEAT = 3'b010,
    MODE_COOLDOWN = 3'b100
  } oh_mode_t;

  typedef struct packed {
    logic signed [11:0] temp_min;
    logic signed [11:0] temp_max;
    logic [9:0]         hum_min;
    logic [9:0]         hum_max;
    logic [13:0]        co2_max;
    logic               local_mode;
    logic signed [11:0] temp_trip;
    logic signed [11:0] temp_release;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic [13:0]        co2_ppm;
    logic [31:0]        now_ms;
    logic               light_request;
  } item_t;

  typedef struct packed {
    logic        heating;
    logic        venting;
    logic        humidifying;
    logic        light_on;
    oh_mode_t    mode;
    logic        post_armed;
    logic [31:0] post_start_ms;
  } state_t;

  // Input tdata layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [2:0]         pad;
    logic               light_request;
    logic [31:0]        now_ms;
    logic [13:0]        co2_ppm;
    logic [9:0]         humidity;
    logic signed [11:0] temperature;
  } in_word_t;

  // Output tdata layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [6:0] pad;
    logic [1:0] overheat_status;
    logic [2:0] alarm_code;
    logic       light_drive;
    logic       humidifier_on;
    logic       vent_drive;
    logic       heater_on;
  } out_word_t;

endpackage

FILE: rtl/chc_cfg_regs.sv
// Setpoint and mode registers written through the configuration port.
`timescale 1ns / 1ps

module chc_cfg_regs
  import chc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_min      <= 12'sd180;
      cfg_r.temp_max      <= 12'sd240;
      cfg_r.hum_min       <= 10'd800;
      cfg_r.hum_max       <= 10'd950;
      cfg_r.co2_max       <= 14'd1000;
      cfg_r.local_mode    <= 1'b1;
      cfg_r.temp_trip     <= 12'sd350;
      cfg_r.temp_release  <= 12'sd300;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_MIN:      cfg_r.temp_min      <= cfg_wdata[11:0];
        REG_TEMP_MAX:      cfg_r.temp_max      <= cfg_wdata[11:0];
        REG_HUM_MIN:       cfg_r.hum_min       <= cfg_wdata[9:0];
        REG_HUM_MAX:       cfg_r.hum_max       <= cfg_wdata[9:0];
        REG_CO2_MAX:       cfg_r.co2_max       <= cfg_wdata[13:0];
        REG_LOCAL_MODE:    cfg_r.local_mode    <= cfg_wdata[0];
        REG_TEMP_TRIP:     cfg_r.temp_trip     <= cfg_wdata[11:0];
        REG_TEMP_RELEASE:  cfg_r.temp_release  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/chc_eval.sv
// Evaluation of one request: hysteresis flags, overheat mode, relays and alarm.
`timescale 1ns / 1ps

module chc_eval
  import chc_pkg::*;
(
  input  item_t     item,
  input  state_t    st,
  input  cfg_t      cfg,
  output state_t    st_nxt,
  output out_word_t res
);

  cmp_t        t, h, c;
  cmp_t        tmin, tmax, hmin, hmax, cmax, tcrit, trec;
  logic        co2_valid;
  logic        vent_prev, need;
  logic [31:0] elapsed;
  logic        in_window;

  always_comb begin
    t     = cmp_t'(item.temperature);
    h     = cmp_t'(item.humidity);
    c     = cmp_t'(item.co2_ppm);
    tmin  = cmp_t'(cfg.temp_min);
    tmax  = cmp_t'(cfg.temp_max);
    hmin  = cmp_t'(cfg.hum_min);
    hmax  = cmp_t'(cfg.hum_max);
    cmax  = cmp_t'(cfg.co2_max);
    tcrit = cmp_t'(cfg.temp_trip);
    trec  = cmp_t'(cfg.temp_release);
    co2_valid = (item.co2_ppm != '0);

    st_nxt    = st;
    res       = '0;
    vent_prev = st.venting;
    need      = 1'b0;
    elapsed   = '0;
    in_window = 1'b0;

    case (item.kind)
      KIND_EVAL: begin
        if (st.mode == MODE_OVERHEAT) begin
          // Overheat holds the vent on and everything else off.
          res.vent_drive = 1'b1;
        end else begin
          res.light_drive = st.light_on;
          if (st.mode == MODE_COOLDOWN) begin
            st_nxt.mode    = MODE_NORMAL;
            st_nxt.venting = 1'b0;
            res.alarm_code = ALARM_OVERHEAT_CLEAR;
            vent_prev      = 1'b0;
          end
          if (cfg.local_mode) begin
            need = (t >= tmax + VENT_MARGIN) || (co2_valid && (c >= cmax + CO2_BAND));
            if (vent_prev) begin
              need = !((t < tmax - VENT_MARGIN) && (!co2_valid || (c < cmax - CO2_BAND)));
            end
            // A vent turn-off arms the post-vent window from this timestamp.
            if (vent_prev && !need) begin
              st_nxt.post_armed    = 1'b1;
              st_nxt.post_start_ms = item.now_ms;
            end
            st_nxt.venting = need;

            if (need) begin
              st_nxt.heating = 1'b0;
            end else if (st.heating) begin
              if (t >= tmax) st_nxt.heating = 1'b0;
            end else if (t <= tmin - TEMP_BAND) begin
              st_nxt.heating = 1'b1;
            end

            if (need || (t >= HUMID_BLOCK_TEMP)) begin
              st_nxt.humidifying = 1'b0;
            end else if (st.humidifying) begin
              if ((h >= hmax) || (t >= HUMID_STOP_TEMP)) st_nxt.humidifying = 1'b0;
            end else if (h <= hmin - HUM_BAND) begin
              st_nxt.humidifying = 1'b1;
            end

            // The window is only looked at while the vent is off.
            elapsed = item.now_ms - st_nxt.post_start_ms;
            if (!need && st_nxt.post_armed) begin
              in_window = (elapsed >= POST_DELAY_MS) && (elapsed < POST_END_MS);
              if (elapsed >= POST_END_MS) st_nxt.post_armed = 1'b0;
            end

            res.vent_drive    = need;
            res.heater_on     = st_nxt.heating;
            res.humidifier_on = st_nxt.humidifying || in_window;

            if (t > tmax + ALARM_TEMP_MARGIN) begin
              res.alarm_code = ALARM_HIGH_TEMP;
            end else if (t < tmin - ALARM_TEMP_MARGIN) begin
              res.alarm_code = ALARM_LOW_TEMP;
            end else if (h > hmax + ALARM_HUM_MARGIN) begin
              res.alarm_code = ALARM_HIGH_HUM;
            end else if (h < hmin - ALARM_HUM_MARGIN) begin
              res.alarm_code = ALARM_LOW_HUM;
            end else if (co2_valid && (c > cmax + ALARM_CO2_MARGIN)) begin
              res.alarm_code = ALARM_HIGH_CO2;
            end
          end
        end
      end
      KIND_REPORT: begin
        if (t >= tcrit) begin
          if (st.mode != MODE_OVERHEAT) begin
            st_nxt.mode    = MODE_OVERHEAT;
            res.alarm_code = ALARM_OVERHEAT;
          end
        end else if ((t < trec) && (st.mode == MODE_OVERHEAT)) begin
          st_nxt.mode = MODE_COOLDOWN;
        end
        res.light_drive = st.light_on;
      end
      KIND_LIGHT: begin
        st_nxt.light_on = item.light_request;
        res.light_drive = item.light_request;
      end
      default: begin
        res.light_drive = st.light_on;
      end
    endcase

    unique case (st_nxt.mode)
      MODE_NORMAL:   res.overheat_status = STATUS_NONE;
      MODE_OVERHEAT: res.overheat_status = STATUS_ACTIVE;
      MODE_COOLDOWN: res.overheat_status = STATUS_RECOVERY;
      default:       res.overheat_status = STATUS_NONE;
    endcase
  end

endmodule

FILE: rtl/climate_hysteresis_controller.sv
// Top level of the climate hysteresis controller: request, state and result registers.
`timescale 1ns / 1ps

// Climate hysteresis controller. Every request (sensor sample, overheat report
// or light command) is taken into an input register, evaluated against the
// setpoints and the controller state, and its single result is placed in an
// output register. The block takes one request per clock cycle while the
// result channel is not stalled; a result is valid on the result channel once
// it has passed the input register, the evaluation stage and the result
// register. The evaluation stage between the input and result registers is
// also where the hysteresis flags and overheat mode are updated. The output
// register holds a result while out_tready is low, and the input register
// keeps accepting until both stages are full. Setpoint writes take effect on
// the next cycle and are meant to be done while no request is in flight.

module climate_hysteresis_controller
  import chc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // temperature[11:0], humidity[21:12], co2_ppm[35:22], now_ms[67:36],
  // light_request[68], zeros above
  input  logic [71:0]            in_tdata,
  // kind[1:0]
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // heater_on[0], vent_drive[1], humidifier_on[2], light_drive[3],
  // alarm_code[6:4], overheat_status[8:7], zeros above
  output logic [15:0]            out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg;
  in_word_t  in_word;
  item_t     s1_item_r;
  logic      s1_valid_r;
  logic      s1_adv;
  state_t    st_r, st_nxt;
  out_word_t res;
  out_word_t out_data_r;
  logic      out_valid_r;

  chc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_word   = in_word_t'(in_tdata);
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.kind          <= in_tuser;
      s1_item_r.temperature   <= in_word.temperature;
      s1_item_r.humidity      <= in_word.humidity;
      s1_item_r.co2_ppm       <= in_word.co2_ppm;
      s1_item_r.now_ms        <= in_word.now_ms;
      s1_item_r.light_request <= in_word.light_request;
    end
  end

  chc_eval u_eval (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Controller state moves only when a request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.heating       <= 1'b0;
      st_r.venting       <= 1'b0;
      st_r.humidifying   <= 1'b0;
      st_r.light_on      <= 1'b0;
      st_r.mode          <= MODE_NORMAL;
      st_r.post_armed    <= 1'b0;
      st_r.post_start_ms <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/chc_checker.sv
// Port-level checker for the climate hysteresis controller and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chc_checker
  import chc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [71:0]            in_tdata,
  input logic [1:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [15:0]            out_tdata,
  input logic                   cfg_we,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_wdata
);

  out_word_t ow;
  assign ow = out_word_t'(out_tdata);

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

  `ASSERT_CLK(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  `ASSERT_CLK(a_overheat_vent, out_tvalid && (ow.overheat_status == STATUS_ACTIVE) && (ow.alarm_code == ALARM_NONE) && ow.vent_drive |-> !ow.heater_on && !ow.humidifier_on && !ow.light_drive, "relays not off with forced vent")

  `ASSERT_CLK(a_heat_vent_excl, out_tvalid |-> !(ow.heater_on && ow.vent_drive), "heater and vent both on")

  `ASSERT_CLK(a_alarm_overheat, out_tvalid && (ow.alarm_code == ALARM_OVERHEAT) |-> ow.overheat_status == STATUS_ACTIVE, "overheat alarm without active status")

endmodule

bind climate_hysteresis_controller chc_checker u_chc_checker (.*);
